[rtl/feel_pkg.sv]
// Package for the two-page flash EEPROM emulation log.
// Holds geometry constants, derived widths and the controller state type.
`default_nettype none
package feel_pkg;
    localparam int SLOTS_PER_PAGE = 256;
    localparam int NUM_PAGES      = 2;
    localparam int NUM_KEYS       = 8;

    localparam int TOTAL_SLOTS = NUM_PAGES * SLOTS_PER_PAGE;
    localparam int SLOT_W      = $clog2(SLOTS_PER_PAGE);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int FILL_W      = SLOT_W + 1;
    localparam int KEY_W       = 3;
    localparam int KCNT_W      = KEY_W + 1;
    localparam int VAL_W       = 16;
    localparam int REC_W       = KEY_W + VAL_W;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NOTFOUND = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/feel_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module feel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/flash_eeprom_emulation_log_top.sv]
// Top level of the two-page flash EEPROM emulation log.
// Depends on feel_pkg and feel_ram (one record memory of key and value).
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------
//  item in | i_op, i_key, i_value             | start high, busy low
//  result  | o_read_value, o_status           | o_strobe, one cycle
//
// A write with room on the page appends its record. A read scans slots fill - 1
// down to 1, where fill is the active page's used slot count plus one (at most
// SLOTS_PER_PAGE). A compacting write scans the page, copies each key held to the
// other page; the record memory's single read port scans one slot a cycle.
// Reset is synchronous; a fill count stands for the erased tail, so no clear.
// Results cannot be stalled; busy stays high until the strobe cycle ends.
`default_nettype none
module flash_eeprom_emulation_log_top
    import feel_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    output logic                  o_strobe,
    output logic      [VAL_W-1:0] o_read_value,
    output logic                  o_status
);
    t_state r_state, n_state;

    logic              r_page;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_addr;
    logic [FILL_W-1:0] r_wr;
    logic [KCNT_W-1:0] r_idx;
    logic              r_rd_v;
    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [NUM_KEYS-1:0] r_found;
    logic [VAL_W-1:0]  r_vals [NUM_KEYS];

    logic              accept;
    logic              in_key_ok;
    logic              key_ok;
    logic              page_full;
    logic              in_key_ok_chk;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [REC_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic [REC_W-1:0]  rdata;
    logic [KEY_W-1:0]  rd_key;
    logic              emit_have;
    logic [VAL_W-1:0]  emit_val;
    logic              emit_last;

    assign accept        = start && (r_state == S_IDLE);
    assign in_key_ok     = ({1'b0, i_key} < KCNT_W'(NUM_KEYS));
    assign in_key_ok_chk = in_key_ok;
    assign key_ok        = ({1'b0, r_key} < KCNT_W'(NUM_KEYS));
    assign page_full     = (r_fill == FILL_W'(SLOTS_PER_PAGE));
    assign rd_key        = rdata[REC_W-1:VAL_W];
    assign emit_last     = (r_idx == KCNT_W'(NUM_KEYS - 1));
    assign emit_have     = (r_idx == {1'b0, r_key}) || r_found[r_idx[KEY_W-1:0]];
    assign emit_val      = (r_idx == {1'b0, r_key}) ? r_val : r_vals[r_idx[KEY_W-1:0]];

    feel_ram #(
        .WIDTH(REC_W),
        .DEPTH(TOTAL_SLOTS)
    ) u_rec (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!in_key_ok_chk) begin
                        n_state = S_DONE;
                    end else if (i_op == OP_WRITE && !page_full) begin
                        n_state = S_DONE;
                    end else if (r_fill == FILL_W'(1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == SLOT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_op == OP_WRITE) ? S_EMIT : S_DONE;
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        we           = 1'b0;
        waddr        = {r_page, r_fill[SLOT_W-1:0]};
        wdata        = {i_key, i_value};
        raddr        = {r_page, r_addr};
        busy         = (r_state != S_IDLE);
        o_strobe     = 1'b0;
        o_read_value = '0;
        o_status     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                we = accept && (i_op == OP_WRITE) && in_key_ok && !page_full;
            end
            S_EMIT: begin
                we    = emit_have;
                waddr = {~r_page, r_wr[SLOT_W-1:0]};
                wdata = {r_idx[KEY_W-1:0], emit_val};
            end
            S_DONE: begin
                o_strobe = 1'b1;
                if (r_op == OP_READ) begin
                    if (key_ok && r_found[r_key]) begin
                        o_read_value = r_vals[r_key];
                    end else begin
                        o_status = ST_NOTFOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_page  <= 1'b0;
            r_fill  <= FILL_W'(1);
            r_rd_v  <= 1'b0;
            r_found <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_SCAN);
            if (accept) begin
                r_op    <= i_op;
                r_key   <= i_key;
                r_val   <= i_value;
                r_found <= '0;
                r_addr  <= r_fill[SLOT_W-1:0] - SLOT_W'(1);
                r_idx   <= '0;
                r_wr    <= FILL_W'(1);
                if (i_op == OP_WRITE && in_key_ok && !page_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (r_state == S_SCAN) begin
                r_addr <= r_addr - SLOT_W'(1);
            end
            if (r_rd_v && !r_found[rd_key]) begin
                r_found[rd_key] <= 1'b1;
                r_vals[rd_key]  <= rdata[VAL_W-1:0];
            end
            if (r_state == S_EMIT) begin
                r_idx <= r_idx + KCNT_W'(1);
                if (emit_have) begin
                    r_wr <= r_wr + FILL_W'(1);
                end
                if (emit_last) begin
                    r_page <= ~r_page;
                    r_fill <= r_wr + FILL_W'(emit_have);
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/feel_chk.sv]
// Port-level checker for the flash EEPROM emulation log top level.
// Depends on feel_pkg; bound to flash_eeprom_emulation_log_top below.
`default_nettype none
module feel_chk
    import feel_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_strobe,
    input wire logic [VAL_W-1:0] o_read_value,
    input wire logic             o_status
);
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("strobe outside a busy item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("busy held after result");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_NOTFOUND) |-> (o_read_value == '0))
        else $error("not-found result carries a value");
endmodule

bind flash_eeprom_emulation_log_top feel_chk u_feel_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_read_value(o_read_value),
    .o_status    (o_status)
);
`default_nettype wire

[verif/tb_top.sv]
// Testbench for flash_eeprom_emulation_log_top: directed table, then random items.
// Depends on feel_pkg and the RTL; predicts results with a local model of the two-page log.
`timescale 1ns / 1ps
module tb_top;
    import feel_pkg::*;

    localparam logic [15:0] MARK_ACTIVE  = 16'h55aa;
    localparam logic [15:0] MARK_RETIRED = 16'h0000;
    localparam logic [15:0] ERASED       = 16'hffff;
    localparam int N_RANDOM = 1150;

    typedef struct packed {
        logic        op;
        logic [2:0]  key;
        logic [15:0] value;
        logic        chk;
        logic [15:0] exp_rv;
        logic        exp_st;
    } t_row;

    typedef struct packed {
        logic [15:0] rv;
        logic        st;
    } t_res;

    logic i_clk, i_rst_n, start, i_op;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic busy, o_strobe, o_status;
    logic [VAL_W-1:0] o_read_value;

    flash_eeprom_emulation_log_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_key(i_key), .i_value(i_value),
        .o_strobe(o_strobe), .o_read_value(o_read_value), .o_status(o_status)
    );

    logic [15:0] fl_key [TOTAL_SLOTS];
    logic [15:0] fl_val [TOTAL_SLOTS];
    int          cur_page;
    t_res        pending[$];
    int          errors, n_reads, n_writes, n_compact, n_results;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    function automatic bit find_newest(int k, output logic [15:0] v);
        int base;
        base = cur_page * SLOTS_PER_PAGE;
        v = '0;
        for (int s = SLOTS_PER_PAGE - 1; s >= 1; s--)
            if (fl_key[base + s] == k) begin
                v = fl_val[base + s];
                return 1;
            end
        return 0;
    endfunction

    function automatic void log_reset();
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            fl_key[i] = ERASED;
            fl_val[i] = ERASED;
        end
        fl_key[0] = MARK_ACTIVE;
        cur_page = 0;
    endfunction

    function automatic void log_append(int k, logic [15:0] v);
        int base, nbase, wr, nxt;
        logic [15:0] t;
        bit have;
        base = cur_page * SLOTS_PER_PAGE;
        for (int s = 1; s < SLOTS_PER_PAGE; s++)
            if (fl_key[base + s] == ERASED) begin
                fl_key[base + s] = 16'(k);
                fl_val[base + s] = v;
                return;
            end
        n_compact++;
        nxt = (cur_page + 1) % NUM_PAGES;
        nbase = nxt * SLOTS_PER_PAGE;
        for (int s = 0; s < SLOTS_PER_PAGE; s++) begin
            fl_key[nbase + s] = ERASED;
            fl_val[nbase + s] = ERASED;
        end
        fl_key[nbase] = MARK_ACTIVE;
        fl_key[base] = MARK_RETIRED;
        wr = 1;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (i == k) begin
                t = v;
                have = 1;
            end else begin
                have = find_newest(i, t);
            end
            if (have && wr < SLOTS_PER_PAGE) begin
                fl_key[nbase + wr] = 16'(i);
                fl_val[nbase + wr] = t;
                wr++;
            end
        end
        cur_page = nxt;
    endfunction

    function automatic t_res predict_result(logic op, logic [2:0] k, logic [15:0] v);
        t_res r;
        r = '0;
        if (op == OP_WRITE) begin
            n_writes++;
            if (k < NUM_KEYS) log_append(k, v);
            r.st = ST_OK;
        end else begin
            n_reads++;
            if (k < NUM_KEYS && find_newest(k, r.rv)) r.st = ST_OK;
            else begin
                r.rv = 0;
                r.st = ST_NOTFOUND;
            end
        end
        return r;
    endfunction

    // strobe and result are stable over the cycle; sample mid-cycle
    always @(negedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result rv=%h st=%b", o_read_value, o_status);
            end else begin
                e = pending.pop_front();
                if (e.rv !== o_read_value || e.st !== o_status) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected rv=%h st=%b, got rv=%h st=%b",
                                 e.rv, e.st, o_read_value, o_status);
                end
            end
        end
    end

    task automatic send_item(logic op, logic [2:0] k, logic [15:0] v, int gap,
                             bit use_exp, t_res exp_r, output t_res r);
        repeat (gap) @(posedge i_clk);
        start <= 1;
        i_op <= op;
        i_key <= k;
        i_value <= v;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        r = predict_result(op, k, v);
        pending.push_back(use_exp ? exp_r : r);
        start <= 0;
        @(posedge i_clk);
    endtask

    t_row dir_rows[$];

    initial begin
        t_res r;
        t_res exp_r;
        logic op;
        logic [2:0] k;
        logic [15:0] v;
        int draw, burst;
        errors = 0; n_reads = 0; n_writes = 0; n_compact = 0; n_results = 0;
        start = 0; i_op = 0; i_key = 0; i_value = 0;
        i_rst_n = 0;
        log_reset();
        dir_rows = '{
            '{OP_READ,  3'd0, 16'h0000, 1'b1, 16'h0000, ST_NOTFOUND},
            '{OP_READ,  3'd7, 16'hffff, 1'b1, 16'h0000, ST_NOTFOUND},
            '{OP_WRITE, 3'd0, 16'h0000, 1'b1, 16'h0000, ST_OK},
            '{OP_WRITE, 3'd7, 16'hffff, 1'b1, 16'h0000, ST_OK},
            '{OP_READ,  3'd0, 16'h1234, 1'b1, 16'h0000, ST_OK},
            '{OP_READ,  3'd7, 16'h0000, 1'b1, 16'hffff, ST_OK},
            '{OP_WRITE, 3'd3, 16'h8001, 1'b1, 16'h0000, ST_OK},
            '{OP_WRITE, 3'd3, 16'h7ffe, 1'b1, 16'h0000, ST_OK},
            '{OP_READ,  3'd3, 16'h0000, 1'b1, 16'h7ffe, ST_OK},
            '{OP_READ,  3'd5, 16'h0000, 1'b1, 16'h0000, ST_NOTFOUND},
            '{OP_WRITE, 3'd5, 16'haaaa, 1'b0, 16'h0000, ST_OK},
            '{OP_WRITE, 3'd1, 16'h5555, 1'b0, 16'h0000, ST_OK},
            '{OP_READ,  3'd5, 16'h0000, 1'b0, 16'h0000, ST_OK},
            '{OP_READ,  3'd1, 16'hffff, 1'b0, 16'h0000, ST_OK}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            exp_r.rv = dir_rows[i].exp_rv;
            exp_r.st = dir_rows[i].exp_st;
            send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].value,
                      $urandom_range(0, 3), dir_rows[i].chk, exp_r, r);
            if (dir_rows[i].chk && (r.rv !== exp_r.rv || r.st !== exp_r.st))
                $display("table row %0d disagrees with predictor", i);
        end
        // fill several pages to force compactions: mostly writes, bursts without gaps
        for (int n = 0; n < N_RANDOM; n++) begin
            draw = $urandom_range(0, 99);
            op = (draw < 60) ? OP_WRITE : OP_READ;
            k = $urandom_range(0, 7);
            v = (draw % 7 == 0) ? ((draw & 1) ? 16'hffff : 16'h0000) : 16'($urandom);
            burst = ((n / 100) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (n == N_RANDOM / 2) begin
                while (pending.size() != 0) @(posedge i_clk);
            end
            send_item(op, k, v, burst, 1'b0, '0, r);
        end
        fork
            while (pending.size() != 0) @(posedge i_clk);
            begin
                repeat (SLOTS_PER_PAGE * 4 + 100) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (SLOTS_PER_PAGE + NUM_KEYS + 20) @(posedge i_clk);
        $display("covered %0d reads, %0d writes, %0d compactions, %0d results checked",
                 n_reads, n_writes, n_compact, n_results);
        if (errors == 0 && pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("mismatches: %0d, missing results: %0d", errors, pending.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
